// ===== hw/rtl/assert_macros.svh =====
// Assertion macros of the identifier allocator, used by its top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define NFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define NFA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define NFA_ASSERT(lbl, clk, rst_n, prop)
`define NFA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/nfa_pkg.sv =====
// Package with sizes, types and helpers of the identifier allocator.
package nfa_pkg;

  // Identifier width and the derived geometry of the used-mark store.
  localparam int ID_BITS  = 10;
  localparam int ID_COUNT = 1 << ID_BITS;
  localparam int WORD_W   = (ID_BITS >= 5) ? 32 : (1 << ID_BITS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int WORDS    = ID_COUNT / WORD_W;
  localparam int WIDX_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int STEP_W   = $clog2(WORDS + 2);

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WIDX_W-1:0]  widx_t;
  typedef logic [BIT_W-1:0]   bidx_t;
  typedef logic [STEP_W-1:0]  step_t;

  localparam id_t   ID_NONE   = {ID_BITS{1'b1}};
  localparam widx_t WIDX_MASK = widx_t'(WORDS - 1);

  // Request codes.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Which part of a word the search may take during one step.
  typedef enum logic [1:0] {
    SCAN_HEAD = 2'd0,
    SCAN_BODY = 2'd1,
    SCAN_TAIL = 2'd2
  } scan_kind_e;

  // Access to the used-mark store: one read and one write per cycle.
  typedef struct packed {
    logic  rd_en;
    widx_t rd_addr;
    logic  wr_en;
    widx_t wr_addr;
    word_t wr_data;
  } mark_req_t;

  // Word that holds the mark of an identifier.
  function automatic widx_t word_of(id_t id);
    id_t t;
    t = id >> BIT_W;
    return t[WIDX_W-1:0];
  endfunction

  // Identifier from a word index and a bit position.
  function automatic id_t make_id(widx_t w, bidx_t b);
    id_t t;
    t = id_t'(w);
    return (t << BIT_W) | id_t'(b);
  endfunction

endpackage

// ===== hw/rtl/nfa_ifs.sv =====
// Request and response channel interfaces of the identifier allocator.
interface nfa_req_if import nfa_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  id_t  release_id;

  modport source (output valid, output mode, output release_id, input ready);
  modport sink   (input valid, input mode, input release_id, output ready);
endinterface

interface nfa_rsp_if import nfa_pkg::*; ();
  logic valid;
  logic ready;
  id_t  granted_id;
  logic success;

  modport source (output valid, output granted_id, output success, input ready);
  modport sink   (input valid, input granted_id, input success, output ready);
endinterface

// ===== hw/rtl/next_fit_id_allocator.sv =====
// Allocation: up to words + 1 = 33 word reads, one per cycle, each judged in the next cycle by the
// shared search unit; the result is then loaded into the output register.
// Release: read the word, modify and write it back, then load the result into the output register.
// One request is in flight at a time; a stalled result holds the block in its done state.
// Reset: marks read as free at once through row valid bits, hint set to one,
// no clearing pass, so a request is taken as soon as reset is released.
`include "assert_macros.svh"

module next_fit_id_allocator import nfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  nfa_req_if.sink           req_i,
  nfa_rsp_if.source         rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_REL_RD = 5'b00100,
    ST_REL_WR = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  id_t        hint_q, hint_d;
  widx_t      base_w_q, base_w_d;
  bidx_t      hb_q, hb_d;
  step_t      iss_cnt_q, iss_cnt_d;
  logic       ev_vld_q, ev_vld_d;
  widx_t      ev_widx_q, ev_widx_d;
  scan_kind_e ev_kind_q, ev_kind_d;
  id_t        rel_id_q, rel_id_d;
  id_t        res_id_q, res_id_d;
  logic       res_ok_q, res_ok_d;
  logic       out_vld_q, out_vld_d;
  id_t        out_id_q, out_id_d;
  logic       out_ok_q, out_ok_d;

  mark_req_t  mreq;
  word_t      mark_rdata;
  id_t        start_h;
  widx_t      iss_widx;
  scan_kind_e iss_kind;
  logic       scan_found;
  bidx_t      scan_bit;
  id_t        scan_id;
  bidx_t      rel_bit;
  logic       scan_hit;

  nfa_mark_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .rd_data_o (mark_rdata)
  );

  nfa_word_scan u_scan (
    .data_i     (mark_rdata),
    .widx_i     (ev_widx_q),
    .kind_i     (ev_kind_q),
    .hint_bit_i (hb_q),
    .found_o    (scan_found),
    .bit_o      (scan_bit)
  );

  // Word and range of the next search step, wrapping past the last word.
  assign iss_widx = (base_w_q + iss_cnt_q[WIDX_W-1:0]) & WIDX_MASK;
  always_comb begin
    if (iss_cnt_q == '0) begin
      iss_kind = SCAN_HEAD;
    end else if (iss_cnt_q == step_t'(WORDS)) begin
      iss_kind = SCAN_TAIL;
    end else begin
      iss_kind = SCAN_BODY;
    end
  end

  assign scan_id  = make_id(ev_widx_q, scan_bit);
  assign rel_bit  = rel_id_q[BIT_W-1:0];
  assign start_h  = (hint_q == '0) ? id_t'(1) : hint_q;
  assign scan_hit = (state_q == ST_SCAN) && ev_vld_q && scan_found;

  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    hint_d    = hint_q;
    base_w_d  = base_w_q;
    hb_d      = hb_q;
    iss_cnt_d = iss_cnt_q;
    ev_vld_d  = 1'b0;
    ev_widx_d = ev_widx_q;
    ev_kind_d = ev_kind_q;
    rel_id_d  = rel_id_q;
    res_id_d  = res_id_q;
    res_ok_d  = res_ok_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_id_d  = out_id_q;
    out_ok_d  = out_ok_q;
    mreq      = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.mode == MODE_RELEASE) begin
            rel_id_d = req_i.release_id;
            state_d  = ST_REL_RD;
          end else begin
            base_w_d  = word_of(start_h);
            hb_d      = start_h[BIT_W-1:0];
            iss_cnt_d = '0;
            state_d   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one word read per cycle.
        if (iss_cnt_q <= step_t'(WORDS)) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = iss_widx;
          ev_vld_d     = 1'b1;
          ev_widx_d    = iss_widx;
          ev_kind_d    = iss_kind;
          iss_cnt_d    = iss_cnt_q + step_t'(1);
        end
        // Judge the word read in the previous cycle.
        if (ev_vld_q) begin
          if (scan_found) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = ev_widx_q;
            mreq.wr_data = mark_rdata | (word_t'(1) << scan_bit);
            hint_d       = scan_id + id_t'(1);
            res_id_d     = scan_id;
            res_ok_d     = 1'b1;
            state_d      = ST_DONE;
          end else if (ev_kind_q == SCAN_TAIL) begin
            res_id_d = ID_NONE;
            res_ok_d = 1'b0;
            state_d  = ST_DONE;
          end
        end
      end

      ST_REL_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = word_of(rel_id_q);
        state_d      = ST_REL_WR;
      end

      ST_REL_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = word_of(rel_id_q);
        mreq.wr_data = mark_rdata & ~(word_t'(1) << rel_bit);
        res_id_d     = rel_id_q;
        res_ok_d     = mark_rdata[rel_bit];
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        // Load the output register once it is free or being drained.
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_id_d  = res_id_q;
          out_ok_d  = res_ok_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hint_q    <= id_t'(1);
      iss_cnt_q <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hint_q    <= hint_d;
      iss_cnt_q <= iss_cnt_d;
      ev_vld_q  <= ev_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    base_w_q  <= base_w_d;
    hb_q      <= hb_d;
    ev_widx_q <= ev_widx_d;
    ev_kind_q <= ev_kind_d;
    rel_id_q  <= rel_id_d;
    res_id_q  <= res_id_d;
    res_ok_q  <= res_ok_d;
    out_id_q  <= out_id_d;
    out_ok_q  <= out_ok_d;
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.granted_id = out_id_q;
  assign rsp_o.success    = out_ok_q;

  // A granted identifier is never zero and never the failure code.
  `NFA_ASSERT_NEVER(a_grant_legal, clk_i, rst_ni, scan_hit && (scan_id == '0 || scan_id == ID_NONE))
  // The hint follows the identifier just granted.
  `NFA_ASSERT(a_hint_follows, clk_i, rst_ni, scan_hit |=> (hint_q == $past(scan_id) + id_t'(1)))
  // The search never runs past the wrapped tail step.
  `NFA_ASSERT(a_scan_bound, clk_i, rst_ni, (state_q == ST_SCAN) |-> (iss_cnt_q <= step_t'(WORDS + 1)))
  // An accepted request always leaves the idle state.
  `NFA_ASSERT(a_leave_idle, clk_i, rst_ni, (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE))

endmodule

// ===== hw/rtl/nfa_mark_store.sv =====
// Used-mark store: one word memory with per-row valid bits cleared at reset.
module nfa_mark_store import nfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mark_req_t req_i,
  output word_t     rd_data_o
);

  word_t              mem_q [WORDS];
  logic [WORDS-1:0]   row_vld_q;
  word_t              rdata_q;
  logic               rvld_q;

  // Memory array: registered read, single write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  // A row never written since reset reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hw/rtl/nfa_word_scan.sv =====
// Search unit: masks one mark word and finds its lowest free identifier.
module nfa_word_scan import nfa_pkg::*; (
  input  word_t      data_i,
  input  widx_t      widx_i,
  input  scan_kind_e kind_i,
  input  bidx_t      hint_bit_i,
  output logic       found_o,
  output bidx_t      bit_o
);

  word_t cand;

  // Free bits inside the allowed range, never identifier zero or all ones.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      case (kind_i)
        SCAN_HEAD: cand[i] = !data_i[i] && (bidx_t'(i) >= hint_bit_i);
        SCAN_TAIL: cand[i] = !data_i[i] && (bidx_t'(i) < hint_bit_i);
        SCAN_BODY: cand[i] = !data_i[i];
        default:   cand[i] = 1'b0;
      endcase
      if (widx_i == '0 && i == 0) begin
        cand[i] = 1'b0;
      end
      if (widx_i == WIDX_MASK && i == WORD_W - 1) begin
        cand[i] = 1'b0;
      end
    end
  end

  // Priority encoder, lowest position wins.
  always_comb begin
    bit_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        bit_o = bidx_t'(i);
      end
    end
  end

  assign found_o = |cand;

endmodule
